/* hdl/stripe_read_splitter_macros.svh */
// Assertion macros shared by the stripe read splitter RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef STRIPE_READ_SPLITTER_MACROS_SVH
`define STRIPE_READ_SPLITTER_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define SRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define SRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/srs_pkg.sv */
// Shared widths, register indexes, types and helpers of the stripe read splitter.
// No dependencies.
`default_nettype none

package srs_pkg;

  localparam int unsigned OFF_W  = 48;  // volume and disk byte offsets
  localparam int unsigned CNT_W  = 15;  // byte counts and segment lengths
  localparam int unsigned CS_W   = 32;  // chunk size
  localparam int unsigned DC_W   = 5;   // disk count register
  localparam int unsigned CPD_W  = 32;  // chunks per disk
  localparam int unsigned DISK_W = 4;   // disk index on the result port
  localparam int unsigned DIV_W  = CS_W + DC_W;  // chunk size times disk count

  localparam int unsigned MAX_DISKS      = 16;
  localparam int unsigned MAX_SEGMENTS   = 64;
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_STRIPE_UNIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISK_COUNT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_PER_DISK = 2'd2;

  localparam logic [CS_W-1:0]  STRIPE_UNIT_RST     = 32'd524288;
  localparam logic [DC_W-1:0]  DISK_COUNT_RST      = 5'd1;
  localparam logic [CPD_W-1:0] CHUNKS_PER_DISK_RST = 32'd0;

  typedef struct packed {
    logic [CS_W-1:0]  stripe_unit;
    logic [DC_W-1:0]  disk_count;
    logic [CPD_W-1:0] chunks_per_disk;
  } cfg_t;

  // One classified request, handed from the front to the back.
  typedef struct packed {
    logic             err;       // beyond end of volume
    logic [DC_W-1:0]  disk;      // disk of the first chunk
    logic [OFF_W-1:0] base;      // row times chunk size, modulo 2^48
    logic [CS_W-1:0]  in_chunk;  // byte offset inside the first chunk
    logic [CNT_W-1:0] count;     // bytes requested
  } cmd_t;

  // Clamp the disk count to the supported number of disks.
  function automatic logic [DC_W-1:0] eff_disks(input logic [DC_W-1:0] dc);
    if (32'(dc) > MAX_DISKS) return DC_W'(MAX_DISKS);
    return dc;
  endfunction

endpackage

`default_nettype wire

/* hdl/srs_front.sv */
// Front of the stripe read splitter: range check and address division.
// Depends on srs_pkg.
`default_nettype none

module srs_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  srs_pkg::cfg_t              cfg_i,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic [srs_pkg::OFF_W-1:0]  byte_offset_i,
  input  logic [srs_pkg::CNT_W-1:0]  byte_count_i,
  output logic                       cmd_valid_o,
  input  logic                       cmd_ready_i,
  output srs_pkg::cmd_t              cmd_o
);
  import srs_pkg::*;

  localparam int unsigned PD_W    = CPD_W + CS_W;
  localparam int unsigned CAP_W   = PD_W + DC_W;
  localparam int unsigned REM_W   = DIV_W + 1;
  localparam int unsigned PIECE_W = 16;               // OFF_W is a multiple of this
  localparam int unsigned NPIECE  = OFF_W / PIECE_W;
  localparam int unsigned PROD_W  = PIECE_W + CS_W;
  localparam int unsigned STEP_W  = $clog2(OFF_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DSK  = 3'd5;
  localparam logic [2:0] ST_ROW  = 3'd6;
  localparam logic [2:0] ST_PUSH = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PD_W-1:0]   pd_q, pd_d;
  logic [DIV_W-1:0]  dvs_q, dvs_d;
  logic [CAP_W-1:0]  cap_q, cap_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [OFF_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DC_W-1:0]   dsk_q, dsk_d;
  logic [OFF_W-1:0]  acc_q, acc_d;
  logic              err_q, err_d;

  logic [DC_W-1:0]   nd;
  logic [OFF_W:0]    end_sum;
  logic              in_range;
  logic [REM_W-1:0]  rem_sh;
  logic              div_ge;
  logic [DIV_W-1:0]  cs_sh;
  logic              dsk_ge;
  logic [PROD_W-1:0] prod;

  assign nd       = eff_disks(cfg_i.disk_count);
  assign end_sum  = {1'b0, off_q} + {{(OFF_W + 1 - CNT_W){1'b0}}, cnt_q};
  assign in_range = (CAP_W'(off_q) < cap_q) && (CAP_W'(end_sum) <= cap_q);
  assign rem_sh   = {rem_q[DIV_W-1:0], quo_q[OFF_W-1]};
  assign div_ge   = rem_sh >= {1'b0, dvs_q};
  assign cs_sh    = DIV_W'(cfg_i.stripe_unit) << step_q;
  assign dsk_ge   = rem_q[DIV_W-1:0] >= cs_sh;
  assign prod     = PROD_W'(quo_q[OFF_W-1 -: PIECE_W]) * PROD_W'(cfg_i.stripe_unit);

  always_comb begin
    state_d = state_q;
    off_d   = off_q;
    cnt_d   = cnt_q;
    pd_d    = pd_q;
    dvs_d   = dvs_q;
    cap_d   = cap_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    step_d  = step_q;
    dsk_d   = dsk_q;
    acc_d   = acc_q;
    err_d   = err_q;
    case (state_q)
      ST_IDLE: begin
        if (push_i) begin
          off_d   = byte_offset_i;
          cnt_d   = byte_count_i;
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        pd_d    = PD_W'(cfg_i.chunks_per_disk) * PD_W'(cfg_i.stripe_unit);
        dvs_d   = DIV_W'(cfg_i.stripe_unit) * DIV_W'(nd);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        cap_d   = CAP_W'(pd_q) * CAP_W'(nd);
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (in_range) begin
          err_d   = 1'b0;
          rem_d   = '0;
          quo_d   = off_q;
          step_d  = STEP_W'(OFF_W - 1);
          state_d = ST_DIV;
        end else begin
          err_d   = 1'b1;
          dsk_d   = '0;
          acc_d   = '0;
          rem_d   = '0;
          state_d = ST_PUSH;
        end
      end
      ST_DIV: begin
        // Restoring division of the offset by one full stripe row.
        rem_d = div_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
        quo_d = {quo_q[OFF_W-2:0], div_ge};
        if (step_q == '0) begin
          step_d  = STEP_W'(DC_W - 1);
          dsk_d   = '0;
          state_d = ST_DSK;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_DSK: begin
        // Split the row remainder into disk and offset inside the chunk.
        if (dsk_ge) rem_d = rem_q - REM_W'(cs_sh);
        dsk_d = {dsk_q[DC_W-2:0], dsk_ge};
        if (step_q == '0) begin
          step_d  = STEP_W'(NPIECE - 1);
          acc_d   = '0;
          state_d = ST_ROW;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_ROW: begin
        // Row times chunk size, one 16-bit piece of the row per cycle.
        acc_d = (acc_q << PIECE_W) + OFF_W'(prod);
        quo_d = quo_q << PIECE_W;
        if (step_q == '0) begin
          state_d = ST_PUSH;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_PUSH: begin
        if (cmd_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    cnt_q  <= cnt_d;
    pd_q   <= pd_d;
    dvs_q  <= dvs_d;
    cap_q  <= cap_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    dsk_q  <= dsk_d;
    acc_q  <= acc_d;
    err_q  <= err_d;
  end

  assign full_o      = state_q != ST_IDLE;
  assign cmd_valid_o = state_q == ST_PUSH;
  assign cmd_o       = '{err: err_q, disk: dsk_q, base: acc_q,
                         in_chunk: rem_q[CS_W-1:0], count: cnt_q};

endmodule

`default_nettype wire

/* hdl/srs_cmd_fifo.sv */
// Short command queue between the front and the back of the splitter.
// Depends on srs_pkg.
`default_nettype none

module srs_cmd_fifo #(
  parameter int unsigned Depth = srs_pkg::CMD_FIFO_DEPTH  // 2 or more
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  srs_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output srs_pkg::cmd_t rd_data_o
);
  import srs_pkg::*;

  localparam int unsigned PTR_W  = $clog2(Depth);
  localparam int unsigned FILL_W = $clog2(Depth + 1);

  cmd_t              mem_q [Depth];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              do_wr, do_rd;

  assign wr_ready_o = fill_q != FILL_W'(Depth);
  assign rd_valid_o = fill_q != '0;
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

`default_nettype wire

/* hdl/srs_back.sv */
// Back of the stripe read splitter: walks chunks and emits one segment a cycle unless the output is stalled.
// Depends on srs_pkg.
`default_nettype none

module srs_back #(
  parameter int unsigned MaxSegments = srs_pkg::MAX_SEGMENTS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  srs_pkg::cfg_t               cfg_i,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  srs_pkg::cmd_t               cmd_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [srs_pkg::DISK_W-1:0]  disk_index_o,
  output logic [srs_pkg::OFF_W-1:0]   disk_offset_o,
  output logic [srs_pkg::CNT_W-1:0]   seg_length_o,
  output logic                        status_o,
  output logic                        last_o
);
  import srs_pkg::*;

  localparam int unsigned SEG_W = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;

  logic             busy_q;
  logic             err_q;
  logic [DC_W-1:0]  disk_q;
  logic [OFF_W-1:0] base_q;
  logic [CS_W-1:0]  in_chunk_q;
  logic [CNT_W-1:0] rem_q;
  logic [SEG_W-1:0] seg_q;

  logic              out_valid_q;
  logic [DISK_W-1:0] disk_index_q;
  logic [OFF_W-1:0]  disk_offset_q;
  logic [CNT_W-1:0]  seg_length_q;
  logic              status_q;
  logic              last_q;

  logic [DC_W-1:0]  nd;
  logic [CS_W-1:0]  room;
  logic [CS_W-1:0]  len_w;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] rem_next;
  logic             fin;
  logic             adv;
  logic             take;

  assign nd          = eff_disks(cfg_i.disk_count);
  assign room        = cfg_i.stripe_unit - in_chunk_q;
  assign len_w       = (CS_W'(rem_q) < room) ? CS_W'(rem_q) : room;
  assign len         = CNT_W'(len_w);
  assign rem_next    = rem_q - len;
  assign fin         = err_q || (rem_next == '0) || (seg_q == SEG_W'(MaxSegments - 1));
  assign adv         = busy_q && (!out_valid_q || pop_i);
  assign cmd_ready_o = !busy_q;
  assign take        = cmd_valid_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
      end else if (adv && fin) begin
        busy_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      err_q      <= cmd_i.err;
      disk_q     <= cmd_i.disk;
      base_q     <= cmd_i.base;
      in_chunk_q <= cmd_i.in_chunk;
      rem_q      <= cmd_i.count;
      seg_q      <= '0;
    end else if (adv) begin
      // Step to the start of the next chunk.
      rem_q      <= rem_next;
      in_chunk_q <= '0;
      seg_q      <= seg_q + 1'b1;
      if (disk_q + 1'b1 == nd) begin
        disk_q <= '0;
        base_q <= base_q + OFF_W'(cfg_i.stripe_unit);
      end else begin
        disk_q <= disk_q + 1'b1;
      end
    end
    if (adv) begin
      disk_index_q  <= err_q ? '0 : disk_q[DISK_W-1:0];
      disk_offset_q <= err_q ? '0 : base_q + OFF_W'(in_chunk_q);
      seg_length_q  <= err_q ? '0 : len;
      status_q      <= err_q;
      last_q        <= fin;
    end
  end

  assign empty_o       = !out_valid_q;
  assign disk_index_o  = disk_index_q;
  assign disk_offset_o = disk_offset_q;
  assign seg_length_o  = seg_length_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

/* hdl/stripe_read_splitter.sv */
// Top level of the striped-volume read splitter; uses srs_pkg, srs_front,
// srs_cmd_fifo, srs_back and stripe_read_splitter_macros.svh.
// An in-range request passes the front's capacity check, the 48-step offset
// divider, the 5-step disk split and the row multiply in 16-bit pieces; an
// out-of-range request skips them. Then one segment per cycle unless pop stalls.
// The front takes a new request only after handing the last one on. Reset clears control.
`default_nettype none

`include "stripe_read_splitter_macros.svh"

module stripe_read_splitter #(
  parameter int unsigned MaxSegments  = srs_pkg::MAX_SEGMENTS,   // 1 to 64
  parameter int unsigned CmdFifoDepth = srs_pkg::CMD_FIFO_DEPTH  // 2 or more
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request queue side
  input  logic                           push,
  output logic                           full,
  input  logic [srs_pkg::OFF_W-1:0]      byte_offset_i,
  input  logic [srs_pkg::CNT_W-1:0]      byte_count_i,
  // result queue side
  output logic                           empty,
  input  logic                           pop,
  output logic [srs_pkg::DISK_W-1:0]     disk_index_o,
  output logic [srs_pkg::OFF_W-1:0]      disk_offset_o,
  output logic [srs_pkg::CNT_W-1:0]      seg_length_o,
  output logic                           status_o,
  output logic                           last_o,
  // register writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import srs_pkg::*;

  // Configuration registers. The user must write them only while the block is idle;
  // the block itself does not enforce this. Both halves read them directly.
  cfg_t cfg_q;

  cmd_t front_cmd;
  logic front_cmd_valid, front_cmd_ready;
  cmd_t back_cmd;
  logic back_cmd_valid, back_cmd_ready;

  // Take every register write beat at once; drop writes to unknown indexes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stripe_unit     <= STRIPE_UNIT_RST;
      cfg_q.disk_count      <= DISK_COUNT_RST;
      cfg_q.chunks_per_disk <= CHUNKS_PER_DISK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STRIPE_UNIT:     cfg_q.stripe_unit     <= cfg_data_i[CS_W-1:0];
        REG_DISK_COUNT:      cfg_q.disk_count      <= cfg_data_i[DC_W-1:0];
        REG_CHUNKS_PER_DISK: cfg_q.chunks_per_disk <= cfg_data_i[CPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: hold one request, check it against the capacity and resolve the
  // first chunk's disk, row base and offset inside the chunk.
  srs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push),
    .full_o        (full),
    .byte_offset_i (byte_offset_i),
    .byte_count_i  (byte_count_i),
    .cmd_valid_o   (front_cmd_valid),
    .cmd_ready_i   (front_cmd_ready),
    .cmd_o         (front_cmd)
  );

  // Queue so the front can start the next request while the back still
  // emits segments of the previous one.
  srs_cmd_fifo #(
    .Depth (CmdFifoDepth)
  ) u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_cmd_valid),
    .wr_ready_o (front_cmd_ready),
    .wr_data_i  (front_cmd),
    .rd_valid_o (back_cmd_valid),
    .rd_ready_i (back_cmd_ready),
    .rd_data_o  (back_cmd)
  );

  // Back: advance chunk by chunk, one segment per cycle into the output
  // register; stall only when that register is full and not popped.
  srs_back #(
    .MaxSegments (MaxSegments)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_valid_i   (back_cmd_valid),
    .cmd_ready_o   (back_cmd_ready),
    .cmd_i         (back_cmd),
    .empty_o       (empty),
    .pop_i         (pop),
    .disk_index_o  (disk_index_o),
    .disk_offset_o (disk_offset_o),
    .seg_length_o  (seg_length_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  // An error result is a single, empty, final beat.
  `SRS_ASSERT_IMP(a_err_result_clean, !empty && status_o,
    (disk_index_o == '0) && (disk_offset_o == '0) && (seg_length_o == '0) && last_o,
    "error result carries location or is not last")

  // A segment never spans more than one chunk.
  `SRS_ASSERT_IMP(a_seg_within_chunk, !empty && !status_o,
    CS_W'(seg_length_o) <= cfg_q.stripe_unit, "segment longer than a chunk")

  // The front holds one request at a time.
  `SRS_ASSERT_NXT(a_front_busy_after_accept, push && !full, full,
    "front ready again right after an accept beat")

endmodule

`default_nettype wire

/* tb/srs_seg_checker.sv */
`timescale 1ns / 1ps
// Segment checker for the stripe read splitter: tracks the volume registers,
// expands each accepted request into its disk segments and compares result beats.
// Depends on srs_pkg.

module srs_seg_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic                           full_i,
  input  logic [srs_pkg::OFF_W-1:0]      byte_offset_i,
  input  logic [srs_pkg::CNT_W-1:0]      byte_count_i,
  input  logic                           empty_i,
  input  logic                           pop_i,
  input  logic [srs_pkg::DISK_W-1:0]     disk_index_i,
  input  logic [srs_pkg::OFF_W-1:0]      disk_offset_i,
  input  logic [srs_pkg::CNT_W-1:0]      seg_length_i,
  input  logic                           status_i,
  input  logic                           last_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    err_count_o,
  output int unsigned                    segs_pending_o,
  output logic [63:0]                    vol_bytes_o
);
  import srs_pkg::*;

  typedef struct packed {
    logic [DISK_W-1:0] disk;
    logic [OFF_W-1:0]  offset;
    logic [CNT_W-1:0]  len;
    logic              status;
    logic              last;
  } segment_t;

  logic [CS_W-1:0]  stripe_unit_q;
  logic [DC_W-1:0]  disk_count_q;
  logic [CPD_W-1:0] chunks_per_disk_q;
  segment_t         segs_due[$];
  segment_t         want;

  function automatic longint unsigned active_disks();
    if (disk_count_q > MAX_DISKS) return MAX_DISKS;
    return 64'(disk_count_q);
  endfunction

  // Saturate the volume size to all ones when it does not fit in 64 bits.
  function automatic longint unsigned volume_bytes();
    longint unsigned per_disk, nd;
    per_disk = 64'(chunks_per_disk_q) * 64'(stripe_unit_q);
    nd = active_disks();
    if (nd == 0 || per_disk == 0) return 0;
    if (per_disk > 64'hFFFF_FFFF_FFFF_FFFF / nd) return 64'hFFFF_FFFF_FFFF_FFFF;
    return per_disk * nd;
  endfunction

  function automatic void expand_request(input logic [OFF_W-1:0] offs,
                                         input logic [CNT_W-1:0] cnt);
    longint unsigned cap, left, cs, nd, chunk, in_chunk, room, len;
    int unsigned k;
    segment_t s;
    cap  = volume_bytes();
    left = 64'(cnt);
    if (64'(offs) >= cap || 64'(offs) + left > cap) begin
      s = '{disk: '0, offset: '0, len: '0, status: 1'b1, last: 1'b1};
      segs_due.push_back(s);
      return;
    end
    cs       = 64'(stripe_unit_q);
    nd       = active_disks();
    chunk    = 64'(offs) / cs;
    in_chunk = 64'(offs) % cs;
    if (left == 0) begin
      s = '{disk: DISK_W'(chunk % nd), offset: OFF_W'((chunk / nd) * cs + in_chunk),
            len: '0, status: 1'b0, last: 1'b1};
      segs_due.push_back(s);
      return;
    end
    k = 0;
    while (left != 0 && k < MAX_SEGMENTS) begin
      room = cs - in_chunk;
      len  = (left < room) ? left : room;
      left = left - len;
      s.disk   = DISK_W'(chunk % nd);
      s.offset = OFF_W'((chunk / nd) * cs + in_chunk);
      s.len    = CNT_W'(len);
      s.status = 1'b0;
      s.last   = (left == 0) || (k == MAX_SEGMENTS - 1);
      segs_due.push_back(s);
      k++;
      in_chunk = 0;
      chunk++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stripe_unit_q     = STRIPE_UNIT_RST;
      disk_count_q      = DISK_COUNT_RST;
      chunks_per_disk_q = CHUNKS_PER_DISK_RST;
      segs_due.delete();
      err_count_o       = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_STRIPE_UNIT:     stripe_unit_q     = cfg_data_i[CS_W-1:0];
          REG_DISK_COUNT:      disk_count_q      = cfg_data_i[DC_W-1:0];
          REG_CHUNKS_PER_DISK: chunks_per_disk_q = cfg_data_i[CPD_W-1:0];
          default: ;
        endcase
      end
      if (push_i && !full_i) expand_request(byte_offset_i, byte_count_i);
      if (pop_i && !empty_i) begin
        if (segs_due.size() == 0) begin
          $error("result beat with no segment due");
          err_count_o++;
        end else begin
          want = segs_due.pop_front();
          if (disk_index_i !== want.disk) begin
            $error("disk_index expected %0d got %0d", want.disk, disk_index_i);
            err_count_o++;
          end
          if (disk_offset_i !== want.offset) begin
            $error("disk_offset expected 0x%h got 0x%h", want.offset, disk_offset_i);
            err_count_o++;
          end
          if (seg_length_i !== want.len) begin
            $error("seg_length expected %0d got %0d", want.len, seg_length_i);
            err_count_o++;
          end
          if (status_i !== want.status) begin
            $error("status expected %0d got %0d", want.status, status_i);
            err_count_o++;
          end
          if (last_i !== want.last) begin
            $error("last expected %0d got %0d", want.last, last_i);
            err_count_o++;
          end
        end
      end
    end
    segs_pending_o = segs_due.size();
    vol_bytes_o    = volume_bytes();
  end

endmodule

/* tb/tb_stripe_read_splitter.sv */
`timescale 1ns / 1ps
// Top of the stripe read splitter testbench: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Depends on srs_pkg and srs_seg_checker.

module tb_stripe_read_splitter;
  import srs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  // The index above the three registers; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  logic [OFF_W-1:0]      byte_offset;
  logic [CNT_W-1:0]      byte_count;
  logic                  empty;
  logic                  pop;
  logic [DISK_W-1:0]     disk_index;
  logic [OFF_W-1:0]      disk_offset;
  logic [CNT_W-1:0]      seg_length;
  logic                  status;
  logic                  last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned err_count;
  int unsigned segs_pending;
  logic [63:0] vol_bytes;
  int unsigned cycles = 0;

  // Burst modes: while set, the side in question never idles.
  bit push_calm = 1'b0;
  bit pop_calm  = 1'b0;

  stripe_read_splitter dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push          (push),
    .full          (full),
    .byte_offset_i (byte_offset),
    .byte_count_i  (byte_count),
    .empty         (empty),
    .pop           (pop),
    .disk_index_o  (disk_index),
    .disk_offset_o (disk_offset),
    .seg_length_o  (seg_length),
    .status_o      (status),
    .last_o        (last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  srs_seg_checker seg_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push_i         (push),
    .full_i         (full),
    .byte_offset_i  (byte_offset),
    .byte_count_i   (byte_count),
    .empty_i        (empty),
    .pop_i          (pop),
    .disk_index_i   (disk_index),
    .disk_offset_i  (disk_offset),
    .seg_length_i   (seg_length),
    .status_i       (status),
    .last_i         (last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .err_count_o    (err_count),
    .segs_pending_o (segs_pending),
    .vol_bytes_o    (vol_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: end the run with an error once the cycle limit is reached.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: draw a stall before each beat, then hold pop until the beat
  // goes through. A zero stall keeps pop high across beats.
  initial begin
    int unsigned stall;
    pop = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 23) == 0) pop_calm = !pop_calm;
      stall = pop_calm ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Present one request beat after a random gap and hold it until accepted.
  task automatic send_request(input logic [OFF_W-1:0] off, input logic [CNT_W-1:0] cnt);
    int unsigned gap;
    @(negedge clk);
    if ($urandom_range(0, 23) == 0) push_calm = !push_calm;
    gap = push_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_offset <= off;
    byte_count  <= cnt;
    push        <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  // Drop push and wait until every segment due has come out, then let the
  // block settle.
  task automatic quiesce();
    @(negedge clk);
    push <= 1'b0;
    while (segs_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Raise the register write and hold it until the beat goes through.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Reprogram the stripe set while idle. Junk goes into the unused upper bits
  // of the disk count word; only the low bits count.
  task automatic load_volume(input logic [CS_W-1:0] cs, input logic [DC_W-1:0] dc,
                             input logic [CPD_W-1:0] cpd);
    quiesce();
    write_reg(REG_STRIPE_UNIT, cs);
    write_reg(REG_DISK_COUNT, {(CFG_DATA_W - DC_W)'($urandom), dc});
    write_reg(REG_CHUNKS_PER_DISK, cpd);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pick a random stripe set, mostly sane, sometimes degenerate.
  task automatic choose_volume();
    logic [CS_W-1:0]  cs;
    logic [DC_W-1:0]  dc;
    logic [CPD_W-1:0] cpd;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      cs = 32'd512 << $urandom_range(0, 8);
    else if (pick < 75) cs = $urandom_range(512, 70000);
    else if (pick < 85) cs = $urandom_range(1, 511);  // can hit the segment cap
    else if (pick < 95) cs = $urandom;
    else                cs = '0;
    pick = $urandom_range(0, 99);
    if (pick < 90)      dc = DC_W'($urandom_range(1, 16));
    else if (pick < 97) dc = DC_W'($urandom_range(17, 31));  // clamped
    else                dc = '0;
    pick = $urandom_range(0, 99);
    if (pick < 60)      cpd = $urandom_range(1, 64);
    else if (pick < 85) cpd = $urandom_range(1, 100000);
    else if (pick < 97) cpd = $urandom;
    else                cpd = '0;
    load_volume(cs, dc, cpd);
  endtask

  // Mostly in-range reads, some reads hugging the end of the volume and the
  // rest raw noise over the whole offset field.
  task automatic random_request();
    longint unsigned cap, lim, off;
    logic [CNT_W-1:0] cnt;
    int unsigned pick, k;
    cap = vol_bytes;
    lim = (cap > (64'd1 << OFF_W)) ? (64'd1 << OFF_W) : cap;
    case ($urandom_range(0, 9))
      0:       cnt = '0;
      1, 2, 3: cnt = CNT_W'($urandom_range(1, 600));
      4, 5, 6: cnt = CNT_W'($urandom_range(1, 4096));
      default: cnt = CNT_W'($urandom_range(0, 32767));
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 70 && lim != 0) begin
      off = {$urandom, $urandom} % lim;
      if (64'(cnt) > cap - off) cnt = CNT_W'(cap - off);
    end else if (pick < 85 && cap != 0 && cap <= (64'd1 << OFF_W)) begin
      k   = $urandom_range(0, 2000);
      off = (64'(k) >= cap) ? 64'd0 : cap - 64'(k);
      cnt = CNT_W'($urandom_range(0, 2100));
    end else begin
      off = {$urandom, $urandom};
    end
    send_request(OFF_W'(off), cnt);
  endtask

  initial begin
    push        = 1'b0;
    byte_offset = '0;
    byte_count  = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_STRIPE_UNIT;
    cfg_data    = '0;
    rst_n       = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Out of reset the volume is empty: everything is beyond end.
    send_request(48'd0, 15'd0);
    send_request(48'h1234, 15'd1);

    // 16 KiB volume: 512-byte chunks over four disks, eight chunks each.
    load_volume(32'd512, 5'd4, 32'd8);
    send_request(48'd0, 15'd0);         // zero length at the origin
    send_request(48'd700, 15'd0);       // zero length inside a chunk
    send_request(48'd100, 15'd1000);    // crosses two chunk borders
    send_request(48'd16383, 15'd1);     // last byte of the volume
    send_request(48'd16384, 15'd0);     // offset at end
    send_request(48'd16000, 15'd500);   // runs past end
    send_request(48'd0, 15'd16384);     // whole volume
    send_request(48'hFFFF_FFFF_FFFF, 15'h7FFF);
    send_request(48'd0, 15'h7FFF);

    // Zero chunk size, then zero disks: capacity collapses to nothing.
    load_volume(32'd0, 5'd4, 32'd8);
    send_request(48'd0, 15'd0);
    load_volume(32'd512, 5'd0, 32'd8);
    send_request(48'd0, 15'd0);

    // Disk count beyond the supported maximum.
    load_volume(32'd4096, 5'd31, 32'd1000);
    send_request(48'd20487, 15'd9000);
    send_request(48'd69632, 15'd1);

    // Tiny chunks: the requests reach or overflow the segment cap.
    load_volume(32'd100, 5'd3, 32'd1000);
    send_request(48'd50, 15'h7FFF);
    send_request(48'd0, 15'd6400);
    send_request(48'd0, 15'd6401);

    // Largest chunks and disks: the capacity saturates.
    load_volume(32'hFFFF_FFFF, 5'd16, 32'hFFFF_FFFF);
    send_request(48'hFFFF_FFFF_FFFF, 15'h7FFF);
    send_request(48'hFFFF_FFFF_0000, 15'd100);
    send_request(48'd0, 15'd0);

    // Unused register index: must leave the mapping alone.
    quiesce();
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_request(48'd1, 15'd1);

    for (int ph = 0; ph < 10; ph++) begin
      choose_volume();
      for (int n = 0; n < 35; n++) random_request();
    end

    // Drain, then give stray beats a chance to show up.
    quiesce();
    repeat (72) @(negedge clk);
    if (err_count == 0 && segs_pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
